// ===== hdl/rqt_pkg.sv =====
// ============================================================================
// rqt_pkg
// Shared types and constants for the retransmit queue timer.
// ============================================================================
`default_nettype none

package rqt_pkg;

    localparam int CNT_W  = 25;   // slot countdown
    localparam int END_W  = 24;   // count * interval
    localparam int IVL_W  = 16;   // resend interval
    localparam int REF_W  = 16;
    localparam int LEN_W  = 16;
    localparam int RCNT_W = 8;    // resend count register
    localparam int DLY_W  = 16;   // first delay register
    localparam int ACT_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OCC_OUT_W  = 4;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 3;

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ENQ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DROP = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESEND_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESEND_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY     = 2'd2;

    localparam logic [RCNT_W-1:0] RESEND_COUNT_RST    = 8'd2;
    localparam logic [IVL_W-1:0]  RESEND_INTERVAL_RST = 16'd1000;
    localparam logic [DLY_W-1:0]  FIRST_DELAY_RST     = 16'd0;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_TICK,
        OP_LOAD,
        OP_SHIFT,
        OP_CLEAR
    } cell_op_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [END_W-1:0] end_cnt;
        logic [IVL_W-1:0] ivl;
        logic [IVL_W-1:0] phase;    // ticks left to next send once inside the window
        logic [REF_W-1:0] pkt_ref;
        logic [LEN_W-1:0] pkt_len;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   load;
    } cell_ctl_t;

endpackage : rqt_pkg

`default_nettype wire

// ===== hdl/rqt_cell.sv =====
// ============================================================================
// rqt_cell
// One queue slot. Load, shift (take the neighbor's entry) and clear; the head
// cell also runs the countdown and send phase on a tick.
// ============================================================================
`default_nettype none

module rqt_cell
    import rqt_pkg::*;
#(
    parameter bit HEAD = 1'b0
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    input  wire logic      load_en,
    input  wire entry_t    nbr,      // entry of the next cell up
    output entry_t         entry
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    entry_t           pay_reg, pay_next;   // cnt field unused here

    always_comb
    begin
        cnt_next = cnt_reg;
        pay_next = pay_reg;
        case (ctl.op)
            OP_TICK:
            begin
                if (HEAD && cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    // inside the send window: step the phase
                    if ({1'b0, pay_reg.end_cnt} >= cnt_reg)
                    begin
                        if (pay_reg.phase == '0)
                            pay_next.phase = pay_reg.ivl - IVL_W'(1);
                        else
                            pay_next.phase = pay_reg.phase - IVL_W'(1);
                    end
                end
            end
            OP_LOAD:
            begin
                if (load_en)
                begin
                    cnt_next = ctl.load.cnt;
                    pay_next = ctl.load;
                end
            end
            OP_SHIFT:
            begin
                cnt_next = nbr.cnt;
                pay_next = nbr;
            end
            OP_CLEAR:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        pay_reg <= pay_next;
    end

    always_comb
    begin
        entry     = pay_reg;
        entry.cnt = cnt_reg;
    end

endmodule : rqt_cell

`default_nettype wire

// ===== hdl/retransmit_queue_timer.sv =====
// ============================================================================
// retransmit_queue_timer
// Queue of pending packets with a per-packet retransmission countdown.
// ============================================================================
// Usage:
//   s_* : one beat per item. s_tuser = action (tick, enqueue, drop head);
//         s_tdata = packet reference and length (enqueue only).
//   m_* : one beat per item: send flag, give-up flag, drop flag in m_tuser,
//         send reference, length and occupancy in m_tdata.
//   cfg_* : register writes (resend count, interval, first delay); always
//         ready, take effect for packets enqueued afterward.
// Path: an input beat is captured, the multiply stage forms count * interval,
//   and the cell update step then writes the result register. Only one item
//   is in the update path, so no new beat is taken until the last one's
//   update is done.
// Storage is a row of SLOTS cells; a drop shifts each cell into its lower
//   neighbor, a tick works on the head cell only, and a give-up clears all
//   countdowns at once. Occupied cells always form a prefix, so the
//   fill count picks the enqueue cell.
// Reset: all countdowns zero (queue empty), registers to 2 / 1000 / 0.
// Stall: a finished result sits in the output register; the next input beat
//   is still taken, and its update waits until that result is taken.
// ============================================================================
`default_nettype none

module retransmit_queue_timer
    import rqt_pkg::*;
#(
    parameter int SLOTS = 10
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] packet_ref, [31:16] packet_len
    input  wire logic [ACT_W-1:0]       s_tuser,   // [1:0] action
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // [15:0] send_ref, [31:16] send_len,
                                                   // [35:32] occupancy, [39:36] zero
    output logic [OUT_TUSER_W-1:0]      m_tuser,   // [0] send_valid, [1] gave_up,
                                                   // [2] enqueue_dropped
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int OCC_W = $clog2(SLOTS);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_EXEC
    } state_t;

    state_t                   state_reg;
    logic [ACT_W-1:0]         act_reg;
    logic [REF_W-1:0]         ref_reg;
    logic [LEN_W-1:0]         len_reg;
    logic [END_W-1:0]         prod_reg;
    logic [IVL_W-1:0]         prod_ivl_reg;
    logic [OCC_W-1:0]         occ_reg, occ_next;
    logic                     m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [OUT_TUSER_W-1:0]   m_tuser_reg, m_tuser_next;

    logic [RCNT_W-1:0]        rcnt_reg;
    logic [IVL_W-1:0]         ivl_reg;
    logic [DLY_W-1:0]         dly_reg;

    cell_ctl_t                ctl;
    entry_t                   cell_q [SLOTS];
    entry_t                   head;
    logic                     fire;
    logic [CNT_W-1:0]         total;
    logic                     send, gave_up, dropped;
    logic [OCC_W+OCC_OUT_W-1:0] occ_ext;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcnt_reg <= RESEND_COUNT_RST;
            ivl_reg  <= RESEND_INTERVAL_RST;
            dly_reg  <= FIRST_DELAY_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RESEND_COUNT:    rcnt_reg <= cfg_data[RCNT_W-1:0];
                REG_RESEND_INTERVAL: ivl_reg  <= cfg_data;
                REG_FIRST_DELAY:     dly_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    // --- cell row ------------------------------------------------------------
    generate
        for (genvar i = 0; i < SLOTS; i++)
        begin : g_cell
            entry_t nbr;
            logic   load_en;
            if (i == SLOTS - 1)
            begin : g_top
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = cell_q[i+1];
            end
            assign load_en = (occ_reg == OCC_W'(i));

            rqt_cell #(
                .HEAD (i == 0)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .load_en (load_en),
                .nbr     (nbr),
                .entry   (cell_q[i])
            );
        end
    endgenerate

    assign head = cell_q[0];

    // --- update step -----------------------------------------------------------
    assign fire  = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);
    assign total = {1'b0, prod_reg} + CNT_W'(dly_reg);

    always_comb
    begin
        ctl.op             = OP_HOLD;
        ctl.load.cnt       = total;
        ctl.load.end_cnt   = prod_reg;
        ctl.load.ivl       = prod_ivl_reg;
        ctl.load.phase     = '0;
        ctl.load.pkt_ref   = ref_reg;
        ctl.load.pkt_len   = len_reg;
        send     = 1'b0;
        gave_up  = 1'b0;
        dropped  = 1'b0;
        occ_next = occ_reg;
        case (act_reg)
            ACT_TICK:
            begin
                if (head.cnt != '0)
                begin
                    // send when inside the window and on a phase boundary
                    send = ({1'b0, head.end_cnt} >= head.cnt) && (head.phase == '0);
                    if (head.cnt == CNT_W'(1))
                    begin
                        ctl.op   = OP_CLEAR;
                        gave_up  = 1'b1;
                        occ_next = '0;
                    end
                    else
                    begin
                        ctl.op = OP_TICK;
                    end
                end
            end
            ACT_ENQ:
            begin
                if (occ_reg == OCC_FULL)
                    dropped = 1'b1;
                else if (total != '0)
                begin
                    ctl.op   = OP_LOAD;
                    occ_next = occ_reg + OCC_W'(1);
                end
            end
            ACT_DROP:
            begin
                ctl.op = OP_SHIFT;
                if (occ_reg != '0)
                    occ_next = occ_reg - OCC_W'(1);
            end
            default:
            begin
                ctl.op = OP_HOLD;
            end
        endcase
        if (!fire)
        begin
            ctl.op   = OP_HOLD;
            occ_next = occ_reg;
        end
    end

    assign occ_ext = {{OCC_OUT_W{1'b0}}, occ_next};

    always_comb
    begin
        m_tdata_next = '0;
        m_tdata_next[REF_W-1:0]           = send ? head.pkt_ref : '0;
        m_tdata_next[REF_W+LEN_W-1:REF_W] = send ? head.pkt_len : '0;
        m_tdata_next[REF_W+LEN_W+OCC_OUT_W-1:REF_W+LEN_W] = occ_ext[OCC_OUT_W-1:0];
        m_tuser_next = {dropped, gave_up, send};
    end

    // --- control: state, occupancy, result valid flag -------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (fire)
                    begin
                        state_reg <= S_IDLE;
                        occ_reg   <= occ_next;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            act_reg <= s_tuser;
            ref_reg <= s_tdata[REF_W-1:0];
            len_reg <= s_tdata[REF_W+LEN_W-1:REF_W];
        end
        if (state_reg == S_MUL)
        begin
            prod_reg     <= END_W'(rcnt_reg) * END_W'(ivl_reg);
            prod_ivl_reg <= ivl_reg;
        end
        if (fire)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

endmodule : retransmit_queue_timer

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for retransmit_queue_timer: a directed table of
// ticks, enqueues, drops and register writes, then randomized phases under
// several timer settings, all scored beat by beat against typed
// expectations or a software copy of the slot queue.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import rqt_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int NSLOT       = 10;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 200;
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off
    localparam int DRAIN_WAIT  = 12;       // margin after the last owed result is back
    localparam int CYCLE_LIMIT = 200000;

    // action code the block must ignore
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

    // one result beat, unpacked from m_tdata / m_tuser
    typedef struct packed {
        logic              send_valid;
        logic [REF_W-1:0]  send_ref;
        logic [LEN_W-1:0]  send_len;
        logic              gave_up;
        logic              dropped;
        logic [3:0]        occ;
    } tx_report_t;

    // directed table row: an item beat or a register write
    typedef struct packed {
        logic              is_reg;
        logic [1:0]        code;       // action, or register index
        logic [15:0]       a;          // packet_ref, or register data
        logic [15:0]       b;          // packet_len
        logic              known;      // typed-in expectation in want
        tx_report_t        want;
    } plan_row_t;

    // ------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [15:0] packet_ref, [31:16] packet_len
    logic [ACT_W-1:0]       s_tuser   = '0;   // [1:0] action
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [15:0] send_ref, [31:16] send_len,
                                              // [35:32] occupancy
    logic [OUT_TUSER_W-1:0] m_tuser;          // [0] send_valid, [1] gave_up,
                                              // [2] enqueue_dropped
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // bench controls
    logic   gaps_on      = 1'b1;   // random idle bursts on both sides
    logic   hold_pending = 1'b0;   // ask the sink for one long hold-off
    logic   hold_done    = 1'b0;
    int     hold_left    = 0;
    int     stall_left   = 0;
    int     cycle_count  = 0;
    int     fail_count   = 0;

    // ------------------------------------------------------------------
    // Shadow queue state and register copies
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   pend_cnt [NSLOT];
    logic [REF_W-1:0]   pend_ref [NSLOT];
    logic [LEN_W-1:0]   pend_len [NSLOT];
    logic [IVL_W-1:0]   pend_ivl [NSLOT];
    logic [END_W-1:0]   pend_end [NSLOT];
    logic [RCNT_W-1:0]  reg_count = RESEND_COUNT_RST;
    logic [IVL_W-1:0]   reg_ivl   = RESEND_INTERVAL_RST;
    logic [DLY_W-1:0]   reg_dly   = FIRST_DELAY_RST;

    tx_report_t  want_q [$];      // results still owed by the block
    tx_report_t  head_want;
    plan_row_t   plan [$];

    retransmit_queue_timer #(.SLOTS(NSLOT)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Queue update for one accepted item; returns the result it owes.
    // Only the head counts down; a give-up wipes every slot.
    // ------------------------------------------------------------------
    function automatic tx_report_t queue_step(input logic [ACT_W-1:0] act,
                                              input logic [REF_W-1:0] pref,
                                              input logic [LEN_W-1:0] plen);
        tx_report_t  res;
        int unsigned c;
        int unsigned iv;
        int unsigned prod;
        int          slot;
        int          n;
        res  = '0;
        slot = -1;
        n    = 0;
        case (act)
            ACT_TICK:
            begin
                c  = 32'(pend_cnt[0]);
                iv = 32'(pend_ivl[0]);
                if (c != 0)
                begin
                    // send only inside the window and on an interval boundary
                    if (iv != 0 && (c % iv) == 0 && c <= 32'(pend_end[0]))
                    begin
                        res.send_valid = 1'b1;
                        res.send_ref   = pend_ref[0];
                        res.send_len   = pend_len[0];
                    end
                    c = c - 1;
                    pend_cnt[0] = CNT_W'(c);
                    if (c == 0)
                    begin
                        for (int i = 0; i < NSLOT; i++)
                        begin
                            pend_cnt[i] = '0;
                            pend_ref[i] = '0;
                            pend_len[i] = '0;
                            pend_ivl[i] = '0;
                            pend_end[i] = '0;
                        end
                        res.gave_up = 1'b1;
                    end
                end
            end
            ACT_ENQ:
            begin
                // lowest free slot; the top slot is never used for enqueue
                for (int i = 0; i < NSLOT - 1; i++)
                    if (slot < 0 && pend_cnt[i] == 0)
                        slot = i;
                if (slot < 0)
                    res.dropped = 1'b1;
                else
                begin
                    prod = 32'(reg_count) * 32'(reg_ivl);
                    pend_cnt[slot] = CNT_W'(prod + 32'(reg_dly));
                    pend_end[slot] = END_W'(prod);
                    pend_ivl[slot] = reg_ivl;
                    pend_ref[slot] = pref;
                    pend_len[slot] = plen;
                end
            end
            ACT_DROP:
            begin
                for (int i = 0; i < NSLOT - 1; i++)
                begin
                    pend_cnt[i] = pend_cnt[i + 1];
                    pend_ref[i] = pend_ref[i + 1];
                    pend_len[i] = pend_len[i + 1];
                    pend_ivl[i] = pend_ivl[i + 1];
                    pend_end[i] = pend_end[i + 1];
                end
                pend_cnt[NSLOT - 1] = '0;
                pend_ref[NSLOT - 1] = '0;
                pend_len[NSLOT - 1] = '0;
                pend_ivl[NSLOT - 1] = '0;
                pend_end[NSLOT - 1] = '0;
            end
            default: ;      // unused action: state untouched
        endcase
        for (int i = 0; i < NSLOT; i++)
            if (pend_cnt[i] != 0)
                n++;
        res.occ = n[3:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    task automatic plan_item(input logic [1:0] act, input logic [15:0] a,
                             input logic [15:0] b);
        plan_row_t row;
        row = '0;
        row.code = act;
        row.a    = a;
        row.b    = b;
        plan.push_back(row);
    endtask

    task automatic plan_known(input logic [1:0] act, input logic [15:0] a,
                              input logic [15:0] b, input logic sv,
                              input logic [15:0] sref, input logic [15:0] slen,
                              input logic gu, input logic dr, input logic [3:0] occ);
        plan_row_t row;
        row = '0;
        row.code  = act;
        row.a     = a;
        row.b     = b;
        row.known = 1'b1;
        row.want  = '{send_valid: sv, send_ref: sref, send_len: slen,
                      gave_up: gu, dropped: dr, occ: occ};
        plan.push_back(row);
    endtask

    task automatic plan_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        plan_row_t row;
        row = '0;
        row.is_reg = 1'b1;
        row.code   = idx;
        row.a      = data;
        plan.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Input side: offer one beat, hold it until taken, then model its result.
    // tvalid stays high on return so back-to-back beats need no re-raise.
    // ------------------------------------------------------------------
    task automatic issue_item(input logic [ACT_W-1:0] act, input logic [15:0] a,
                              input logic [15:0] b, input logic known,
                              input tx_report_t typed);
        tx_report_t res;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {b, a};
        do
            @(posedge clk);
        while (!s_tready);
        res = queue_step(act, a, b);
        want_q.push_back(known ? typed : res);
    endtask

    // random sender gap, one time in six while gaps are on
    task automatic maybe_pause();
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // register write, only once every owed result has come back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        s_tvalid <= 1'b0;
        wait (want_q.size() == 0);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_RESEND_COUNT:    reg_count = data[RCNT_W-1:0];
            REG_RESEND_INTERVAL: reg_ivl   = data[IVL_W-1:0];
            REG_FIRST_DELAY:     reg_dly   = data[DLY_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_pending && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // result scoreboard: each beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (want_q.size() == 0)
            begin
                $error("result beat with nothing expected: tdata %0h tuser %0h",
                       m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                head_want = want_q.pop_front();
                check_field("send_valid",      16'(head_want.send_valid), 16'(m_tuser[0]));
                check_field("gave_up",         16'(head_want.gave_up),    16'(m_tuser[1]));
                check_field("enqueue_dropped", 16'(head_want.dropped),    16'(m_tuser[2]));
                check_field("send_ref",        head_want.send_ref,        m_tdata[15:0]);
                check_field("send_len",        head_want.send_len,        m_tdata[31:16]);
                check_field("occupancy",       16'(head_want.occ),        16'(m_tdata[35:32]));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[retransmit_queue_timer] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [15:0] set_count;
        logic [15:0] set_ivl;
        logic [15:0] set_dly;
        int          pick;

        for (int i = 0; i < NSLOT; i++)
        begin
            pend_cnt[i] = '0;
            pend_ref[i] = '0;
            pend_len[i] = '0;
            pend_ivl[i] = '0;
            pend_end[i] = '0;
        end

        // --- directed table -------------------------------------------
        // reset settings 2 / 1000 / 0: empty-queue cases, one packet
        plan_known(ACT_TICK, 16'h0000, 16'h0000, 0, 0, 0, 0, 0, 0);
        plan_known(ACT_NONE, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0, 0);
        plan_known(ACT_DROP, 16'h0000, 16'h0000, 0, 0, 0, 0, 0, 0);
        plan_known(ACT_ENQ,  16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0, 1);
        // countdown 2000 sits on the window edge: immediate send
        plan_known(ACT_TICK, 16'h0000, 16'h0000, 1, 16'hFFFF, 16'hFFFF, 0, 0, 1);
        plan_known(ACT_TICK, 16'h0000, 16'h0000, 0, 0, 0, 0, 0, 1);
        plan_known(ACT_DROP, 16'h0000, 16'h0000, 0, 0, 0, 0, 0, 0);
        // zero total countdown: accepted, holds nothing, not flagged
        plan_reg(REG_RESEND_COUNT, 16'd0);
        plan_known(ACT_ENQ,  16'hAAAA, 16'h5555, 0, 0, 0, 0, 0, 0);
        // all registers at their top: first tick is ahead of the window
        plan_reg(REG_RESEND_COUNT,    16'd255);
        plan_reg(REG_RESEND_INTERVAL, 16'hFFFF);
        plan_reg(REG_FIRST_DELAY,     16'hFFFF);
        plan_known(ACT_ENQ,  16'h5555, 16'hAAAA, 0, 0, 0, 0, 0, 1);
        plan_known(ACT_TICK, 16'h0000, 16'h0000, 0, 0, 0, 0, 0, 1);
        plan_known(ACT_DROP, 16'h0000, 16'h0000, 0, 0, 0, 0, 0, 0);
        // one-tick countdown: fill, overflow, then send and give-up together
        plan_reg(REG_RESEND_COUNT,    16'd1);
        plan_reg(REG_RESEND_INTERVAL, 16'd1);
        plan_reg(REG_FIRST_DELAY,     16'd0);
        for (int i = 0; i < NSLOT - 1; i++)
            plan_known(ACT_ENQ, 16'(i) * 16'h1111, 16'hFFFF - 16'(i) * 16'h1111,
                       0, 0, 0, 0, 0, 4'(i + 1));
        plan_known(ACT_ENQ,  16'h1234, 16'h5678, 0, 0, 0, 0, 1, 4'(NSLOT - 1));
        plan_known(ACT_TICK, 16'h0000, 16'h0000, 1, 16'h0000, 16'hFFFF, 1, 0, 0);
        // zero interval: never sent, still runs out
        plan_reg(REG_RESEND_COUNT,    16'd3);
        plan_reg(REG_RESEND_INTERVAL, 16'd0);
        plan_reg(REG_FIRST_DELAY,     16'd2);
        plan_item(ACT_ENQ,  16'h0F0F, 16'hF0F0);
        plan_item(ACT_TICK, 16'h0000, 16'h0000);
        plan_item(ACT_TICK, 16'h0000, 16'h0000);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_reg)
                write_reg(plan[i].code, plan[i].a);
            else
            begin
                issue_item(plan[i].code, plan[i].a, plan[i].b, plan[i].known,
                           plan[i].want);
                maybe_pause();
            end
        end

        // --- random phases --------------------------------------------
        // Each phase starts with no owed results (write_reg waits), so the
        // sender also sits idle until every owed result is back.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    // 255 sends in a row before the give-up
                    set_count = 16'd255;
                    set_ivl   = 16'd1;
                    set_dly   = 16'd0;
                end
                1:
                begin
                    // widest interval: one send on reaching the head
                    set_count = 16'd1;
                    set_ivl   = 16'hFFFF;
                    set_dly   = 16'd0;
                end
                2:
                begin
                    // no window at all, only the delay countdown
                    set_count = 16'd0;
                    set_ivl   = 16'($urandom_range(1, 6));
                    set_dly   = 16'($urandom_range(1, 8));
                end
                default:
                begin
                    set_count = 16'($urandom_range(1, 6));
                    set_ivl   = 16'($urandom_range(1, 6));
                    set_dly   = 16'($urandom_range(0, 8));
                end
            endcase
            write_reg(REG_RESEND_COUNT,    set_count);
            write_reg(REG_RESEND_INTERVAL, set_ivl);
            write_reg(REG_FIRST_DELAY,     set_dly);
            gaps_on <= (ph != 5 && ph != PHASES - 1);
            if (ph == 3)
                hold_pending <= 1'b1;     // sink stalls, sender keeps pushing

            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                pick = $urandom_range(0, 99);
                issue_item(pick < 62 ? ACT_TICK : pick < 82 ? ACT_ENQ :
                           pick < 94 ? ACT_DROP : ACT_NONE,
                           16'($urandom), 16'($urandom), 1'b0, '0);
                maybe_pause();
            end
        end

        // --- drain and report -----------------------------------------
        s_tvalid <= 1'b0;
        wait (want_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && want_q.size() == 0)
            $display("[retransmit_queue_timer] OK");
        else
            $display("[retransmit_queue_timer] ERROR");
        $finish;
    end

endmodule
